// ===== rtl/vgsg_pkg.sv =====
// ----------------------------------------------------------------------------
// vgsg_pkg: shared definitions for the vector glyph stroke generator
// Widths, stroke codes, the built-in glyph stroke table and the types that
// pass between the sequencer and its helper units.
// ----------------------------------------------------------------------------
package vgsg_pkg;

	localparam int COORD_W      = 12;
	localparam int CODE_W       = 7;
	localparam int CFG_W        = 6;
	localparam int STORED_ROWS  = 96;
	localparam int STORED_BYTES = 8;
	localparam int BYTE_IDX_W   = $clog2(STORED_BYTES);
	localparam int ROW_IDX_W    = $clog2(STORED_ROWS);
	localparam int STROKES_DEF  = 8;

	// Stream packing: tdata widths rounded up to whole bytes.
	localparam int IN_DATA_W  = ((CODE_W + 2 * COORD_W + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((4 * COORD_W + 7) / 8) * 8;

	localparam logic [7:0]        PEN_LIFT   = 8'hFE;
	localparam logic [7:0]        GLYPH_END  = 8'hFF;
	localparam logic [CODE_W-1:0] FIRST_CODE = 7'h20;

	localparam logic [CFG_W-1:0] ADVANCE_RST = 6'd10;
	localparam logic [CFG_W-1:0] HEIGHT_RST  = 6'd12;

	// Configuration register indexes.
	typedef enum logic {
		CFG_CHAR_ADVANCE = 1'b0,
		CFG_GLYPH_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef logic [STORED_BYTES-1:0][7:0] glyph_row_t;

	typedef struct packed {
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} point_t;

	typedef struct packed {
		logic [COORD_W-1:0] y1;
		logic [COORD_W-1:0] x1;
		logic [COORD_W-1:0] y0;
		logic [COORD_W-1:0] x0;
	} seg_t;

	// Builds one stroke row; the first byte sits in the lowest bits.
	function automatic glyph_row_t g(input logic [7:0] b0, input logic [7:0] b1,
			input logic [7:0] b2, input logic [7:0] b3, input logic [7:0] b4,
			input logic [7:0] b5, input logic [7:0] b6, input logic [7:0] b7);
		glyph_row_t r;
		r = {b7, b6, b5, b4, b3, b2, b1, b0};
		return r;
	endfunction

	// Stroke table indexed by character code minus 0x20. Each byte holds x in
	// the high nibble and y in the low nibble. Rows not listed are all zero.
	function automatic glyph_row_t glyph_row(input logic [ROW_IDX_W-1:0] row);
		glyph_row_t r;
		unique case (row)
			7'd0:  r = g(GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd1:  r = g(8'h40, 8'h32, 8'h52, 8'h40, PEN_LIFT, 8'h44, 8'h4C, GLYPH_END);
			7'd2:  r = g(8'h2A, 8'h26, PEN_LIFT, 8'h6A, 8'h66, GLYPH_END, 8'h00, 8'h00);
			7'd3:  r = g(8'h04, 8'h84, 8'h62, 8'h6A, 8'h88, 8'h08, 8'h2A, 8'h22);
			7'd4:  r = g(8'h62, 8'h26, 8'h6A, PEN_LIFT, 8'h4C, 8'h40, GLYPH_END, 8'h00);
			7'd5:  r = g(8'h00, 8'h8C, PEN_LIFT, 8'h2A, 8'h28, PEN_LIFT, 8'h64, 8'h62);
			7'd6:  r = g(8'h80, 8'h4C, 8'h88, 8'h04, 8'h40, 8'h84, GLYPH_END, 8'h00);
			7'd7:  r = g(8'h26, 8'h6A, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd8:  r = g(8'h60, 8'h24, 8'h28, 8'h6C, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd9:  r = g(8'h20, 8'h64, 8'h68, 8'h2C, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd10: r = g(8'h00, 8'h4C, 8'h80, 8'h08, 8'h88, 8'h00, GLYPH_END, 8'h00);
			7'd11: r = g(8'h16, 8'h76, PEN_LIFT, 8'h49, 8'h43, GLYPH_END, 8'h00, 8'h00);
			7'd12: r = g(8'h20, 8'h42, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd13: r = g(8'h26, 8'h66, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd14: r = g(8'h30, 8'h40, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd15: r = g(8'h00, 8'h8C, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd16: r = g(8'h00, 8'h80, 8'h8C, 8'h0C, 8'h00, 8'h8C, GLYPH_END, 8'h00);
			7'd17: r = g(8'h40, 8'h4C, 8'h3A, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd18: r = g(8'h0C, 8'h8C, 8'h87, 8'h05, 8'h00, 8'h80, GLYPH_END, 8'h00);
			7'd19: r = g(8'h0C, 8'h8C, 8'h80, 8'h00, PEN_LIFT, 8'h06, 8'h86, GLYPH_END);
			7'd20: r = g(8'h0C, 8'h06, 8'h86, PEN_LIFT, 8'h8C, 8'h80, GLYPH_END, 8'h00);
			7'd21: r = g(8'h00, 8'h80, 8'h86, 8'h07, 8'h0C, 8'h8C, GLYPH_END, 8'h00);
			7'd22: r = g(8'h0C, 8'h00, 8'h80, 8'h85, 8'h07, GLYPH_END, 8'h00, 8'h00);
			7'd23: r = g(8'h0C, 8'h8C, 8'h86, 8'h40, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd24: r = g(8'h00, 8'h80, 8'h8C, 8'h0C, 8'h00, PEN_LIFT, 8'h06, 8'h86);
			7'd25: r = g(8'h80, 8'h8C, 8'h0C, 8'h07, 8'h85, GLYPH_END, 8'h00, 8'h00);
			7'd26: r = g(8'h49, 8'h47, PEN_LIFT, 8'h45, 8'h43, GLYPH_END, 8'h00, 8'h00);
			7'd27: r = g(8'h49, 8'h47, PEN_LIFT, 8'h45, 8'h12, GLYPH_END, 8'h00, 8'h00);
			7'd28: r = g(8'h60, 8'h26, 8'h6C, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd29: r = g(8'h14, 8'h74, PEN_LIFT, 8'h18, 8'h78, GLYPH_END, 8'h00, 8'h00);
			7'd30: r = g(8'h20, 8'h66, 8'h2C, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd31: r = g(8'h08, 8'h4C, 8'h88, 8'h44, PEN_LIFT, 8'h41, 8'h40, GLYPH_END);
			7'd32: r = g(8'h84, 8'h40, 8'h04, 8'h08, 8'h4C, 8'h88, 8'h44, 8'h36);
			7'd33: r = g(8'h00, 8'h08, 8'h4C, 8'h88, 8'h80, PEN_LIFT, 8'h04, 8'h84);
			7'd34: r = g(8'h00, 8'h0C, 8'h4C, 8'h8A, 8'h46, 8'h82, 8'h40, 8'h00);
			7'd35: r = g(8'h80, 8'h00, 8'h0C, 8'h8C, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd36: r = g(8'h00, 8'h0C, 8'h4C, 8'h88, 8'h84, 8'h40, 8'h00, GLYPH_END);
			7'd37: r = g(8'h80, 8'h00, 8'h0C, 8'h8C, PEN_LIFT, 8'h06, 8'h66, GLYPH_END);
			7'd38: r = g(8'h00, 8'h0C, 8'h8C, PEN_LIFT, 8'h06, 8'h66, GLYPH_END, 8'h00);
			7'd39: r = g(8'h66, 8'h84, 8'h80, 8'h00, 8'h0C, 8'h8C, GLYPH_END, 8'h00);
			7'd40: r = g(8'h00, 8'h0C, PEN_LIFT, 8'h06, 8'h86, PEN_LIFT, 8'h8C, 8'h80);
			7'd41: r = g(8'h00, 8'h80, PEN_LIFT, 8'h40, 8'h4C, PEN_LIFT, 8'h0C, 8'h8C);
			7'd42: r = g(8'h04, 8'h40, 8'h80, 8'h8C, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd43: r = g(8'h00, 8'h0C, PEN_LIFT, 8'h8C, 8'h06, 8'h60, GLYPH_END, 8'h00);
			7'd44: r = g(8'h80, 8'h00, 8'h0C, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd45: r = g(8'h00, 8'h0C, 8'h48, 8'h8C, 8'h80, GLYPH_END, 8'h00, 8'h00);
			7'd46: r = g(8'h00, 8'h0C, 8'h80, 8'h8C, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd47: r = g(8'h00, 8'h0C, 8'h8C, 8'h80, 8'h00, GLYPH_END, 8'h00, 8'h00);
			7'd48: r = g(8'h00, 8'h0C, 8'h8C, 8'h86, 8'h05, GLYPH_END, 8'h00, 8'h00);
			7'd49: r = g(8'h00, 8'h0C, 8'h8C, 8'h84, 8'h00, PEN_LIFT, 8'h44, 8'h80);
			7'd50: r = g(8'h00, 8'h0C, 8'h8C, 8'h86, 8'h05, PEN_LIFT, 8'h45, 8'h80);
			7'd51: r = g(8'h02, 8'h20, 8'h80, 8'h85, 8'h07, 8'h0C, 8'h6C, 8'h8A);
			7'd52: r = g(8'h0C, 8'h8C, PEN_LIFT, 8'h4C, 8'h40, GLYPH_END, 8'h00, 8'h00);
			7'd53: r = g(8'h0C, 8'h02, 8'h40, 8'h82, 8'h8C, GLYPH_END, 8'h00, 8'h00);
			7'd54: r = g(8'h0C, 8'h40, 8'h8C, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd55: r = g(8'h0C, 8'h20, 8'h44, 8'h60, 8'h8C, GLYPH_END, 8'h00, 8'h00);
			7'd56: r = g(8'h00, 8'h8C, PEN_LIFT, 8'h0C, 8'h80, GLYPH_END, 8'h00, 8'h00);
			7'd57: r = g(8'h0C, 8'h46, 8'h8C, PEN_LIFT, 8'h46, 8'h40, GLYPH_END, 8'h00);
			7'd58: r = g(8'h0C, 8'h8C, 8'h00, 8'h80, PEN_LIFT, 8'h26, 8'h66, GLYPH_END);
			7'd59: r = g(8'h60, 8'h20, 8'h2C, 8'h6C, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd60: r = g(8'h0C, 8'h80, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd61: r = g(8'h20, 8'h60, 8'h6C, 8'h2C, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd62: r = g(8'h26, 8'h4C, 8'h66, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd63: r = g(8'h00, 8'h80, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd64: r = g(8'h2A, 8'h66, GLYPH_END, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
			7'd65: r = g(8'h00, 8'h0C, 8'h7C, 8'h70, 8'h00, GLYPH_END, 8'h00, 8'h00);
			7'd66: r = g(8'h00, 8'h4C, 8'h80, 8'h00, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd67: r = g(8'h06, 8'h86, 8'h87, 8'h07, GLYPH_END, 8'h00, 8'h00, 8'h00);
			7'd91: r = g(8'h60, 8'h42, 8'h4A, 8'h6C, PEN_LIFT, 8'h26, 8'h46, GLYPH_END);
			7'd92: r = g(8'h40, 8'h45, PEN_LIFT, 8'h46, 8'h4C, GLYPH_END, 8'h00, 8'h00);
			7'd93: r = g(8'h40, 8'h62, 8'h6A, 8'h4C, PEN_LIFT, 8'h66, 8'h86, GLYPH_END);
			7'd94: r = g(8'h04, 8'h28, 8'h64, 8'h88, GLYPH_END, 8'h00, 8'h00, 8'h00);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/vgsg_glyph_rom.sv =====
// ----------------------------------------------------------------------------
// vgsg_glyph_rom: stroke row lookup
// Fetches the eight stroke bytes of one character into a register.
// ----------------------------------------------------------------------------
module vgsg_glyph_rom (
	input  logic                      clk,
	input  logic                      load,
	input  logic [vgsg_pkg::CODE_W-1:0] code,
	output vgsg_pkg::glyph_row_t      row_q
);
	import vgsg_pkg::*;

	logic [CODE_W-1:0] row_idx;

	// Control codes also wrap to a row here; the sequencer never scans them.
	assign row_idx = code - FIRST_CODE;

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= glyph_row(row_idx);
		end
	end

endmodule

// ===== rtl/vgsg_point_unit.sv =====
// ----------------------------------------------------------------------------
// vgsg_point_unit: shared point placement unit
// Places one stroke byte on the screen relative to the glyph origin.
// ----------------------------------------------------------------------------
module vgsg_point_unit (
	input  logic [vgsg_pkg::COORD_W-1:0] base,
	input  logic [vgsg_pkg::COORD_W-1:0] baseline,
	input  logic [7:0]                   stroke,
	output vgsg_pkg::point_t             pt
);
	import vgsg_pkg::*;

	// Glyph y grows upwards, so it is taken away from the baseline.
	assign pt.x = base + COORD_W'(stroke[7:4]);
	assign pt.y = baseline - COORD_W'(stroke[3:0]);

endmodule

// ===== rtl/vector_glyph_stroke_generator.sv =====
// ----------------------------------------------------------------------------
// vector_glyph_stroke_generator: character to line segment converter
// Turns each character of a text string into the line segments of its
// built-in vector glyph, advancing the pen column from one character to the
// next.
// ----------------------------------------------------------------------------
//
// Channel  Direction  Beat content
// s_*      in         tdata: char_code, start_x, start_y; tuser: first_char
// m_*      out        tdata: seg_x0, seg_y0, seg_x1, seg_y1; tlast: last_segment
// cfg_*    in         write of char_advance (index 0) or glyph_height (index 1)
//
// A character is taken while the sequencer is idle, after which it examines
// one stroke byte per cycle through the shared point unit. A control code
// starts no scan; a printable character is scanned until the end code or
// until every scanned position is used.
// Each segment is held back by one point so that the final one can carry
// tlast; the scan stalls only while that held segment meets a full output
// register. Reset clears the pen column to zero and loads the register
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vector_glyph_stroke_generator #(
	parameter int STROKES_PER_GLYPH = vgsg_pkg::STROKES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// tdata from bit 0: char_code[6:0], start_x[11:0], start_y[11:0], zero pad.
	input  logic [vgsg_pkg::IN_DATA_W-1:0] s_tdata,
	// tuser: first_char.
	input  logic                           s_tuser,
	// Output stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// tdata from bit 0: seg_x0, seg_y0, seg_x1, seg_y1, twelve bits each.
	output logic [vgsg_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tlast,
	// Configuration write port.
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [vgsg_pkg::CFG_W-1:0]     cfg_data
);
	import vgsg_pkg::*;

	// Only the stored bytes of a row can ever be scanned.
	localparam int SCAN_LEN = (STROKES_PER_GLYPH < STORED_BYTES) ?
		STROKES_PER_GLYPH : STORED_BYTES;
	localparam int POS_W = $clog2(SCAN_LEN + 1);

	state_t state_q, state_d;

	logic [CFG_W-1:0]   advance_q;
	logic [CFG_W-1:0]   height_q;
	logic [COORD_W-1:0] pen_q;
	logic [COORD_W-1:0] base_q;
	logic [COORD_W-1:0] baseline_q;
	logic [POS_W-1:0]   pos_q;
	logic               drawing_q;
	point_t             cur_q;
	logic               pend_valid_q;
	seg_t               pend_q;
	seg_t               out_q;
	logic               out_last_q;
	logic               m_tvalid_q;

	glyph_row_t         row_q;
	point_t             new_pt;

	logic [CODE_W-1:0]  in_code;
	logic [COORD_W-1:0] in_start_x;
	logic [COORD_W-1:0] in_start_y;
	logic [COORD_W-1:0] base_sel;
	logic               accept;
	logic               printable;

	logic [BYTE_IDX_W-1:0] byte_idx;
	logic [7:0]            cur_byte;
	logic                  at_end;
	logic                  is_lift;
	logic                  slot_free;
	logic                  need_out;
	logic                  step_ok;
	logic                  out_load;

	// Unpack the input beat.
	assign in_code    = s_tdata[CODE_W-1:0];
	assign in_start_x = s_tdata[CODE_W +: COORD_W];
	assign in_start_y = s_tdata[CODE_W + COORD_W +: COORD_W];

	assign accept    = s_tvalid && s_tready;
	assign printable = (in_code >= FIRST_CODE);
	assign base_sel  = s_tuser ? in_start_x : pen_q;

	vgsg_glyph_rom u_rom (
		.clk   (clk),
		.load  (accept),
		.code  (in_code),
		.row_q (row_q)
	);

	assign byte_idx = BYTE_IDX_W'(pos_q);
	assign cur_byte = row_q[byte_idx];

	vgsg_point_unit u_point (
		.base     (base_q),
		.baseline (baseline_q),
		.stroke   (cur_byte),
		.pt       (new_pt)
	);

	// The scan ends at the end code or once every scanned position is used.
	assign at_end    = (pos_q == POS_W'(SCAN_LEN)) || (cur_byte == GLYPH_END);
	assign is_lift   = (cur_byte == PEN_LIFT);
	assign slot_free = !m_tvalid_q || m_tready;

	// The held segment leaves when a newer segment replaces it or the glyph
	// ends, in which case it is the last one of the character.
	assign need_out = pend_valid_q && (at_end || (!is_lift && drawing_q));
	assign step_ok  = !need_out || slot_free;
	assign out_load = (state_q == ST_SCAN) && need_out && slot_free;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && printable) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (step_ok && at_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers and the pen column.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			advance_q <= ADVANCE_RST;
			height_q  <= HEIGHT_RST;
			pen_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_CHAR_ADVANCE: advance_q <= cfg_data;
					CFG_GLYPH_HEIGHT: height_q  <= cfg_data;
					default: ;
				endcase
			end
			// Control codes and blank glyphs still move the pen on.
			if (accept) begin
				pen_q <= base_sel + COORD_W'(advance_q);
			end
		end
	end

	// Glyph origin for the character being scanned.
	always_ff @(posedge clk) begin
		if (accept) begin
			base_q     <= base_sel;
			baseline_q <= in_start_y + COORD_W'(height_q);
		end
	end

	// Scan control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			drawing_q    <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				pos_q        <= '0;
				drawing_q    <= 1'b0;
				pend_valid_q <= 1'b0;
			end else if (state_q == ST_SCAN && step_ok) begin
				if (at_end) begin
					pend_valid_q <= 1'b0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
					if (is_lift) begin
						drawing_q <= 1'b0;
					end else begin
						drawing_q <= 1'b1;
						if (drawing_q) begin
							pend_valid_q <= 1'b1;
						end
					end
				end
			end
		end
	end

	// Current pen point and the held segment.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && step_ok && !at_end && !is_lift) begin
			cur_q <= new_pt;
			if (drawing_q) begin
				pend_q <= '{y1: new_pt.y, x1: new_pt.x, y0: cur_q.y, x0: cur_q.x};
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else begin
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q      <= pend_q;
			out_last_q <= at_end;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'(out_q);
	assign m_tlast  = out_last_q;

	// A held segment only exists while a glyph is being scanned.
	a_pend_in_scan : assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> state_q == ST_SCAN)
		else $error("held segment outside a glyph scan");

	// The output register is only loaded when it is free.
	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !m_tvalid_q || m_tready)
		else $error("output register overwritten");

	// The scan position never passes the scan length.
	a_pos_range : assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> pos_q <= POS_W'(SCAN_LEN))
		else $error("scan position out of range");

	// A new scan starts with the pen lifted and nothing held.
	a_scan_start : assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !drawing_q && !pend_valid_q && pos_q == '0)
		else $error("scan not restarted on a new character");

endmodule
